[rtl/uer_pkg.sv]
// Package for the ultrasonic echo ranger: shared types, register indexes,
// reset values and the measurement phase encoding. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

    // Default width of the tick, rise and fall counters
    localparam int COUNT_WIDTH_DEFAULT = 16;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_Q8      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_VALID_MM  = 2'd2;

    // Configuration register widths and reset values
    localparam int CFG_DATA_W = 16;
    localparam int SCALE_W    = 12;
    localparam logic [15:0]        TIMEOUT_RESET   = 16'd2200;
    localparam logic [SCALE_W-1:0] SCALE_RESET     = 12'd696;
    localparam logic [15:0]        MIN_VALID_RESET = 16'd20;

    // Measurement phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RISE = 2'd1,
        PH_FALL = 2'd2
    } phase_t;

    // Configuration register set
    typedef struct packed {
        logic [15:0]        timeout_ticks;
        logic [SCALE_W-1:0] scale_q8;
        logic [15:0]        min_valid_mm;
    } cfg_t;

    // One input item
    typedef struct packed {
        logic start_req;
        logic echo;
    } in_item_t;

    // One result item
    typedef struct packed {
        logic        trigger;
        logic        done_res;
        logic        busy_res;
        logic [15:0] distance_mm;
        logic [15:0] rise_ticks;
        logic [15:0] fall_ticks;
    } result_t;

endpackage

`default_nettype wire

[rtl/uer_cfg_regs.sv]
// Configuration register file of the echo ranger.
// Depends on uer_pkg for register indexes, widths and reset values.
`timescale 1ns / 1ps
`default_nettype none

module uer_cfg_regs
    import uer_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; an index beyond the list changes nothing.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_TIMEOUT_TICKS: cfg_next.timeout_ticks = cfg_wdata;
                CFG_SCALE_Q8:      cfg_next.scale_q8      = cfg_wdata[SCALE_W-1:0];
                CFG_MIN_VALID_MM:  cfg_next.min_valid_mm  = cfg_wdata;
                default:           cfg_next               = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_ticks <= TIMEOUT_RESET;
            cfg_reg.scale_q8      <= SCALE_RESET;
            cfg_reg.min_valid_mm  <= MIN_VALID_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/uer_in_stage.sv]
// Input register stage of the echo ranger: holds one accepted tick.
// Depends on uer_pkg for the input item type.
`timescale 1ns / 1ps
`default_nettype none

module uer_in_stage
    import uer_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire logic s_start_req,
    input  wire logic s_echo,
    input  wire logic take,
    output logic      item_valid,
    output in_item_t  item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // The stage can take a new transfer when empty or when it drains this cycle.
    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.start_req <= s_start_req;
            item_reg.echo      <= s_echo;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

[rtl/uer_core.sv]
// Ranging core: phase machine, tick/rise/fall counters, distance scaling
// and the last good distance. Depends on uer_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uer_core
    import uer_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic fire,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output result_t   result
);

    localparam int CMP_W  = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam int PROD_W = COUNT_WIDTH + SCALE_W;
    localparam int MM_W   = PROD_W - 8;
    localparam int MMC_W  = (MM_W > 16) ? MM_W : 16;

    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [COUNT_WIDTH-1:0] tick_reg;
    logic [COUNT_WIDTH-1:0] tick_next;
    logic [COUNT_WIDTH-1:0] rise_reg;
    logic [COUNT_WIDTH-1:0] rise_next;
    logic [COUNT_WIDTH-1:0] fall_reg;
    logic [COUNT_WIDTH-1:0] fall_next;
    logic [15:0]            last_good_reg;
    logic [15:0]            last_good_next;

    logic [COUNT_WIDTH-1:0] tick_inc;
    logic                   timed_out;
    logic                   finish;
    logic [COUNT_WIDTH-1:0] span_rise;
    logic [COUNT_WIDTH-1:0] span;
    logic [PROD_W-1:0]      product;
    logic [MMC_W-1:0]       mm;
    logic                   mm_valid;
    logic                   mm_sat;

    // Saturating tick increment and the timeout compare
    assign tick_inc  = (tick_reg != {COUNT_WIDTH{1'b1}}) ? tick_reg + 1'b1 : tick_reg;
    assign timed_out = CMP_W'(tick_inc) > CMP_W'(cfg.timeout_ticks);

    // A measurement ends on timeout, or on the echo falling while waiting for it.
    always_comb begin
        case (phase_reg)
            PH_RISE: finish = !item.start_req && timed_out;
            PH_FALL: finish = !item.start_req && (timed_out || !item.echo);
            default: finish = 1'b0;
        endcase
    end

    // Span between the recorded edges; a rise timeout gives zero.
    assign span_rise = (phase_reg == PH_FALL) ? rise_reg : tick_inc;
    assign span      = (tick_inc >= span_rise) ? tick_inc - span_rise : '0;

    // Scale to millimetres, truncated, then check against the minimum.
    assign product  = PROD_W'(span) * PROD_W'(cfg.scale_q8);
    assign mm       = MMC_W'(product[PROD_W-1:8]);
    assign mm_valid = mm > MMC_W'(cfg.min_valid_mm);
    assign mm_sat   = mm > MMC_W'(16'hFFFF);

    // Next phase
    always_comb begin
        phase_next = PH_IDLE;
        if (item.start_req) begin
            phase_next = PH_RISE;
        end else begin
            case (phase_reg)
                PH_RISE: begin
                    if (timed_out) begin
                        phase_next = PH_IDLE;
                    end else if (item.echo) begin
                        phase_next = PH_FALL;
                    end else begin
                        phase_next = PH_RISE;
                    end
                end
                PH_FALL: begin
                    phase_next = finish ? PH_IDLE : PH_FALL;
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // Counters and the last good distance
    always_comb begin
        tick_next      = tick_reg;
        rise_next      = rise_reg;
        fall_next      = fall_reg;
        last_good_next = last_good_reg;
        if (item.start_req) begin
            tick_next = '0;
        end else begin
            case (phase_reg)
                PH_RISE: begin
                    tick_next = tick_inc;
                    if (timed_out) begin
                        rise_next = tick_inc;
                        fall_next = tick_inc;
                    end else if (item.echo) begin
                        rise_next = tick_inc;
                    end
                end
                PH_FALL: begin
                    tick_next = tick_inc;
                    if (finish) begin
                        fall_next = tick_inc;
                    end
                end
                default: tick_next = tick_reg;
            endcase
            if (finish && mm_valid) begin
                last_good_next = mm_sat ? 16'hFFFF : mm[15:0];
            end
        end
    end

    // Result of this tick; the recorded counts are reported in 16 bits.
    always_comb begin
        result.trigger     = item.start_req;
        result.done_res    = finish;
        result.busy_res    = (phase_next == PH_RISE) || (phase_next == PH_FALL);
        result.distance_mm = last_good_next;
        result.rise_ticks  = 16'(rise_next);
        result.fall_ticks  = 16'(fall_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            rise_reg      <= '0;
            fall_reg      <= '0;
            last_good_reg <= '0;
        end else if (fire) begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            rise_reg      <= rise_next;
            fall_reg      <= fall_next;
            last_good_reg <= last_good_next;
        end
    end

endmodule

`default_nettype wire

[rtl/uer_out_stage.sv]
// Output register of the echo ranger: holds one result until transferred.
// Depends on uer_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module uer_out_stage
    import uer_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic load,
    input  result_t   result,
    output logic      out_free,
    output logic      m_valid,
    input  wire logic m_ready,
    output result_t   m_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // Free when empty or when the held result is transferred this cycle.
    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (out_free) begin
            valid_next = load;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

`default_nettype wire

[rtl/ultrasonic_echo_ranger_top.sv]
// Ultrasonic echo ranger, top level.
// Each input transfer is one timer tick carrying a start request and the
// sampled echo level; each tick yields exactly one result transfer with the
// trigger level, done and busy flags, the latest distance in millimetres and
// the recorded rise and fall tick counts.
// m_valid rises once a tick has passed the input register and then the result
// register. Throughput: one tick per cycle while the receiver does not stall,
// set by the state update between the two registers.
// When the receiver stalls, the result register holds its transfer and the
// input register absorbs one more tick before s_ready falls.
// Reset clears both valid flags, returns the phase to idle, zeroes the
// counters and the last good distance, and loads the register defaults
// (timeout 2200 ticks, scale 2.72 mm per tick, minimum 20 mm).
// Configuration is a plain write port: cfg_we with cfg_index and cfg_wdata;
// the user writes it only while no tick is in flight; the block does not enforce it.
// Depends on uer_pkg and the uer_* submodules.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_echo_ranger_top
    import uer_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_start_req,
    input  wire logic                   s_echo,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic                        m_trigger,
    output logic                        m_done_res,
    output logic                        m_busy_res,
    output logic [15:0]                 m_distance_mm,
    output logic [15:0]                 m_rise_ticks,
    output logic [15:0]                 m_fall_ticks
);

    cfg_t     cfg;
    in_item_t item;
    logic     item_valid;
    logic     out_free;
    logic     fire;
    result_t  result;
    result_t  m_result;

    // A tick moves from the input register to the result register when both allow.
    assign fire = item_valid && out_free;

    uer_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    uer_in_stage u_in_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_start_req (s_start_req),
        .s_echo      (s_echo),
        .take        (fire),
        .item_valid  (item_valid),
        .item        (item)
    );

    uer_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .cfg     (cfg),
        .result  (result)
    );

    uer_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .result   (result),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_trigger     = m_result.trigger;
    assign m_done_res    = m_result.done_res;
    assign m_busy_res    = m_result.busy_res;
    assign m_distance_mm = m_result.distance_mm;
    assign m_rise_ticks  = m_result.rise_ticks;
    assign m_fall_ticks  = m_result.fall_ticks;

endmodule

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for the ultrasonic echo ranger top level.
// Drives timer ticks and register writes, predicts every result transfer and
// compares it field by field. Depends on uer_pkg and ultrasonic_echo_ranger_top.
`timescale 1ns / 1ps

module tb;
    import uer_pkg::*;

    // Directed stimulus row: one tick, an optional timeout write before it,
    // and an optional result typed in by hand.
    typedef struct packed {
        logic        start_req;
        logic        echo;
        logic        set_timeout;
        logic [15:0] timeout_val;
        logic        typed;
        result_t     want;
    } dir_row_t;

    localparam result_t RES_RESET       = '0;
    localparam result_t RES_FIRST_START = '{1'b1, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0};
    localparam int      DIR_ROWS_N      = 28;
    localparam int      RANDOM_PHASES   = 8;
    localparam int      ITEMS_PER_PHASE = 220;
    localparam int      MAX_PRINTED     = 50;

    // Default timeout for the first rows, then a timeout of two ticks for the
    // timeout cases.
    localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
        '{1'b0, 1'b1, 1'b0, 16'd0, 1'b1, RES_RESET},       // idle tick after reset
        '{1'b1, 1'b1, 1'b0, 16'd0, 1'b1, RES_FIRST_START}, // echo ignored on start
        '{1'b0, 1'b1, 1'b0, 16'd0, 1'b0, RES_RESET},       // rise
        '{1'b0, 1'b1, 1'b0, 16'd0, 1'b0, RES_RESET},
        '{1'b0, 1'b0, 1'b0, 16'd0, 1'b0, RES_RESET},       // short echo, rejected
        '{1'b1, 1'b0, 1'b0, 16'd0, 1'b0, RES_RESET},
        '{1'b0, 1'b1, 1'b0, 16'd0, 1'b0, RES_RESET},
        '{1'b1, 1'b1, 1'b0, 16'd0, 1'b0, RES_RESET},       // restart while busy
        '{1'b0, 1'b0, 1'b0, 16'd0, 1'b0, RES_RESET},
        '{1'b0, 1'b1, 1'b0, 16'd0, 1'b0, RES_RESET},
        '{1'b0, 1'b1, 1'b0, 16'd0, 1'b0, RES_RESET},
        '{1'b0, 1'b1, 1'b0, 16'd0, 1'b0, RES_RESET},
        '{1'b0, 1'b1, 1'b0, 16'd0, 1'b0, RES_RESET},
        '{1'b0, 1'b1, 1'b0, 16'd0, 1'b0, RES_RESET},
        '{1'b0, 1'b1, 1'b0, 16'd0, 1'b0, RES_RESET},
        '{1'b0, 1'b1, 1'b0, 16'd0, 1'b0, RES_RESET},
        '{1'b0, 1'b1, 1'b0, 16'd0, 1'b0, RES_RESET},
        '{1'b0, 1'b1, 1'b0, 16'd0, 1'b0, RES_RESET},
        '{1'b0, 1'b1, 1'b0, 16'd0, 1'b0, RES_RESET},
        '{1'b0, 1'b0, 1'b0, 16'd0, 1'b0, RES_RESET},       // good distance
        '{1'b1, 1'b0, 1'b1, 16'd2, 1'b0, RES_RESET},
        '{1'b0, 1'b0, 1'b0, 16'd0, 1'b0, RES_RESET},
        '{1'b0, 1'b0, 1'b0, 16'd0, 1'b0, RES_RESET},
        '{1'b0, 1'b1, 1'b0, 16'd0, 1'b0, RES_RESET},       // timeout beats echo
        '{1'b1, 1'b0, 1'b0, 16'd0, 1'b0, RES_RESET},
        '{1'b0, 1'b1, 1'b0, 16'd0, 1'b0, RES_RESET},
        '{1'b0, 1'b1, 1'b0, 16'd0, 1'b0, RES_RESET},
        '{1'b0, 1'b1, 1'b0, 16'd0, 1'b0, RES_RESET}        // timeout waiting for fall
    };

    logic                   aclk;
    logic                   aresetn     = 1'b0;
    logic                   cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = CFG_TIMEOUT_TICKS;
    logic [CFG_DATA_W-1:0]  cfg_wdata   = '0;
    logic                   s_valid     = 1'b0;
    logic                   s_ready;
    logic                   s_start_req = 1'b0;
    logic                   s_echo      = 1'b0;
    logic                   m_valid;
    logic                   m_ready     = 1'b0;
    logic                   m_trigger;
    logic                   m_done_res;
    logic                   m_busy_res;
    logic [15:0]            m_distance_mm;
    logic [15:0]            m_rise_ticks;
    logic [15:0]            m_fall_ticks;

    // Ranger model state and its copy of the registers.
    phase_t      ph;
    logic [15:0] tick_cnt;
    logic [15:0] rise_cnt;
    logic [15:0] fall_cnt;
    logic [15:0] good_mm;
    cfg_t        cfg_model;

    result_t     pending_results [$];
    int          error_count = 0;
    bit          no_idle     = 1'b0;

    ultrasonic_echo_ranger_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_start_req   (s_start_req),
        .s_echo        (s_echo),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_trigger     (m_trigger),
        .m_done_res    (m_done_res),
        .m_busy_res    (m_busy_res),
        .m_distance_mm (m_distance_mm),
        .m_rise_ticks  (m_rise_ticks),
        .m_fall_ticks  (m_fall_ticks)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Safety net against a hung run.
    initial begin
        #2000000;
        $display("ultrasonic_echo_ranger_top test failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
        end
    endtask

    // Converts the span between the rise and fall counts into a distance and
    // keeps it only if it clears the minimum.
    function automatic void settle_distance();
        logic [15:0] span;
        logic [27:0] product;
        logic [19:0] mm;
        span    = (fall_cnt >= rise_cnt) ? (fall_cnt - rise_cnt) : 16'd0;
        product = 28'(span) * 28'(cfg_model.scale_q8);
        mm      = product[27:8];
        if (mm > {4'd0, cfg_model.min_valid_mm}) begin
            good_mm = (mm > 20'hFFFF) ? 16'hFFFF : mm[15:0];
        end
        ph = PH_IDLE;
    endfunction

    // Advances the model by one tick and returns the result it produces.
    function automatic result_t predict_tick(input logic start_req, input logic echo);
        result_t res;
        logic    timed_out;
        res = '0;
        if (start_req) begin
            tick_cnt    = '0;
            ph          = PH_RISE;
            res.trigger = 1'b1;
        end else if (ph == PH_RISE || ph == PH_FALL) begin
            if (tick_cnt != 16'hFFFF) begin
                tick_cnt = tick_cnt + 16'd1;
            end
            timed_out = tick_cnt > cfg_model.timeout_ticks;
            if (ph == PH_RISE) begin
                if (timed_out) begin
                    rise_cnt = tick_cnt;
                    fall_cnt = tick_cnt;
                    settle_distance();
                    res.done_res = 1'b1;
                end else if (echo) begin
                    rise_cnt = tick_cnt;
                    ph       = PH_FALL;
                end
            end else if (timed_out || !echo) begin
                fall_cnt = tick_cnt;
                settle_distance();
                res.done_res = 1'b1;
            end
        end
        res.busy_res    = (ph == PH_RISE || ph == PH_FALL);
        res.distance_mm = good_mm;
        res.rise_ticks  = rise_cnt;
        res.fall_ticks  = fall_cnt;
        return res;
    endfunction

    // Sends one tick after a random gap and files its expected result once
    // the transfer has happened.
    task automatic send_tick(input logic start_req, input logic echo,
                             input logic use_typed = 1'b0, input result_t typed_res = '0);
        int      gap;
        result_t res;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_start_req <= start_req;
        s_echo      <= echo;
        do @(posedge aclk); while (!s_ready);
        res = predict_tick(start_req, echo);
        pending_results.push_back(use_typed ? typed_res : res);
    endtask

    // Stops sending and waits until every expected result has arrived.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            CFG_TIMEOUT_TICKS: cfg_model.timeout_ticks = data;
            CFG_SCALE_Q8:      cfg_model.scale_q8      = data[SCALE_W-1:0];
            CFG_MIN_VALID_MM:  cfg_model.min_valid_mm  = data;
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [15:0] timeout_val, input logic [15:0] scale_val,
                                input logic [15:0] min_val);
        drain_results();
        write_reg(CFG_TIMEOUT_TICKS, timeout_val);
        write_reg(CFG_SCALE_Q8, scale_val);
        write_reg(CFG_MIN_VALID_MM, min_val);
        cfg_we <= 1'b0;
    endtask

    // Mostly complete measurements with random timing, the rest noise with
    // stray starts.
    task automatic run_random(input int n_items);
        int sent;
        int pre_n;
        int high_n;
        int tail_n;
        int noise_n;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 39) == 0) begin
                drain_results();
            end
            if ($urandom_range(0, 9) < 8) begin
                send_tick(1'b1, 1'($urandom_range(0, 1)));
                pre_n = $urandom_range(0, 6);
                repeat (pre_n) send_tick(1'b0, 1'b0);
                high_n = $urandom_range(0, 30);
                repeat (high_n) send_tick(1'b0, 1'b1);
                send_tick(1'b0, 1'b0);
                tail_n = $urandom_range(0, 2);
                repeat (tail_n) send_tick(1'b0, 1'($urandom_range(0, 1)));
                sent += 2 + pre_n + high_n + tail_n;
            end else begin
                noise_n = $urandom_range(1, 8);
                repeat (noise_n) begin
                    send_tick($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
                end
                sent += noise_n;
            end
        end
    endtask

    // Result side: random stalls, each transfer checked against the oldest
    // expectation. Sampling starts once reset has been released.
    initial begin
        int      stall;
        result_t want;
        wait (aresetn === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected", m_distance_mm, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_trigger !== want.trigger)
                    report_mismatch("trigger", m_trigger, want.trigger);
                if (m_done_res !== want.done_res)
                    report_mismatch("done_res", m_done_res, want.done_res);
                if (m_busy_res !== want.busy_res)
                    report_mismatch("busy_res", m_busy_res, want.busy_res);
                if (m_distance_mm !== want.distance_mm)
                    report_mismatch("distance_mm", m_distance_mm, want.distance_mm);
                if (m_rise_ticks !== want.rise_ticks)
                    report_mismatch("rise_ticks", m_rise_ticks, want.rise_ticks);
                if (m_fall_ticks !== want.fall_ticks)
                    report_mismatch("fall_ticks", m_fall_ticks, want.fall_ticks);
            end
        end
    end

    // Main sequence.
    initial begin
        int          w;
        logic [15:0] to_val;
        logic [15:0] sc_val;
        logic [15:0] mn_val;

        ph                      = PH_IDLE;
        tick_cnt                = '0;
        rise_cnt                = '0;
        fall_cnt                = '0;
        good_mm                 = '0;
        cfg_model.timeout_ticks = TIMEOUT_RESET;
        cfg_model.scale_q8      = SCALE_RESET;
        cfg_model.min_valid_mm  = MIN_VALID_RESET;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table.
        for (int i = 0; i < DIR_ROWS_N; i++) begin
            if (DIR_ROWS[i].set_timeout) begin
                drain_results();
                write_reg(CFG_TIMEOUT_TICKS, DIR_ROWS[i].timeout_val);
                cfg_we <= 1'b0;
            end
            send_tick(DIR_ROWS[i].start_req, DIR_ROWS[i].echo,
                      DIR_ROWS[i].typed, DIR_ROWS[i].want);
        end

        // Random phases over a spread of register settings.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    to_val = 16'($urandom_range(4, 40));
                    sc_val = 16'($urandom_range(0, 4095));
                    mn_val = 16'($urandom_range(0, 400));
                end
                1: begin
                    to_val = 16'd0;
                    sc_val = 16'd4095;
                    mn_val = 16'd0;
                end
                2: begin
                    to_val = 16'hFFFF;
                    sc_val = 16'd0;
                    mn_val = 16'hFFFF;
                end
                3: begin
                    to_val = TIMEOUT_RESET;
                    sc_val = 16'(SCALE_RESET);
                    mn_val = MIN_VALID_RESET;
                end
                default: begin
                    to_val = 16'($urandom_range(1, 60));
                    sc_val = 16'($urandom_range(1, 4095));
                    mn_val = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 600));
                end
            endcase
            apply_config(to_val, sc_val, mn_val);
            no_idle = (p == 3);
            run_random(ITEMS_PER_PHASE);
        end
        no_idle = 1'b0;

        // Final drain, bounded.
        s_valid <= 1'b0;
        for (w = 0; w < 5000 && pending_results.size() != 0; w++) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (pending_results.size() != 0) begin
            report_mismatch("results never delivered", pending_results.size(), 0);
        end

        if (error_count == 0) begin
            $display("ultrasonic_echo_ranger_top test passed");
        end else begin
            $display("ultrasonic_echo_ranger_top test failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/uer_pkg.sv
rtl/uer_cfg_regs.sv
rtl/uer_in_stage.sv
rtl/uer_core.sv
rtl/uer_out_stage.sv
rtl/ultrasonic_echo_ranger_top.sv
verif/tb.sv
